// File: src/bpfe_pkg.sv
// Shared types and constants for the bin-packing fitness evaluator.
// Depends on nothing; used by the controller, the datapath and the top level.
package bpfe_pkg;

	localparam int CNT_W     = 9;   // item_count, used_bins, item counter
	localparam int CNT_EXT_W = 13;  // room to compare a count with the largest depth
	localparam int CAP_W     = 24;  // bin_capacity and bin loads
	localparam int SIZE_W    = 16;  // item_size field
	localparam int KEY_W     = 17;  // item_key field
	localparam int EPOCH_W   = 8;   // candidate tag kept beside each bin load
	localparam int IN_DATA_W  = 40;
	localparam int OUT_DATA_W = 16;
	localparam int CFG_IDX_W  = 1;

	localparam logic [KEY_W-1:0]    KEY_ONE     = 17'd65536;
	localparam logic [KEY_W-1:0]    KEY_HALF    = 17'd32768;
	localparam logic [CAP_W-1:0]    LOAD_MAX    = 24'hFFFFFF;
	localparam logic [EPOCH_W-1:0]  EPOCH_FIRST = 8'd1;
	localparam logic [EPOCH_W-1:0]  EPOCH_LAST  = 8'hFF;
	localparam logic [EPOCH_W-1:0]  EPOCH_CLEAR = 8'd0;

	localparam logic [CFG_IDX_W-1:0] REG_ITEM_COUNT   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_BIN_CAPACITY = 1'b1;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_RUN,
		ST_DRAIN
	} ctrl_state_t;

	typedef struct packed {
		logic accept;       // item request taken this cycle
		logic last;         // that item closes the candidate
		logic clr_wr;       // clearing pass writes one entry
		logic epoch_reset;  // clearing pass done, restart tags
	} bpfe_cmd_t;

	typedef struct packed {
		logic [CNT_W-1:0] n_eff;
		logic             s1_valid;
		logic             s1_last;
		logic             s2_valid;
		logic             s2_last;
		logic             out_valid;
		logic             epoch_final;
	} bpfe_stat_t;

endpackage

// File: src/bpfe_ctrl.sv
// Controller: input handshake, item counting, clearing pass sequencing.
// Depends on bpfe_pkg; drives the datapath through bpfe_cmd_t.
module bpfe_ctrl
	import bpfe_pkg::*;
#(
	parameter int MAX_ITEMS = 256,
	parameter int BIN_W     = $clog2(MAX_ITEMS)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  bpfe_stat_t       stat,
	output bpfe_cmd_t        cmd,
	output logic [BIN_W-1:0] clr_addr
);

	localparam logic [BIN_W-1:0] CLR_END = BIN_W'(MAX_ITEMS - 1);

	ctrl_state_t      state_q, state_d;
	logic [CNT_W-1:0] acc_q;
	logic [BIN_W-1:0] clr_q;
	logic             next_last;
	logic             last_in_flight;
	logic             ready;

	assign next_last      = ({1'b0, acc_q} + (CNT_W+1)'(1)) >= {1'b0, stat.n_eff};
	assign last_in_flight = (stat.s1_valid && stat.s1_last) || (stat.s2_valid && stat.s2_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			acc_q   <= '0;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.accept) begin
				acc_q <= next_last ? '0 : acc_q + CNT_W'(1);
			end
			if (state_q == ST_CLEAR) begin
				clr_q <= (clr_q == CLR_END) ? '0 : clr_q + BIN_W'(1);
			end
		end
	end

	always_comb begin
		state_d         = state_q;
		ready           = 1'b0;
		cmd.accept      = 1'b0;
		cmd.last        = next_last;
		cmd.clr_wr      = 1'b0;
		cmd.epoch_reset = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (clr_q == CLR_END) begin
					cmd.epoch_reset = 1'b1;
					state_d         = ST_RUN;
				end
			end
			ST_RUN: begin
				// a closing item waits for a free result slot
				ready      = !next_last || (!stat.out_valid && !last_in_flight);
				cmd.accept = s_tvalid && ready;
				if (cmd.accept && next_last && stat.epoch_final) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!stat.s1_valid && !stat.s2_valid) begin
					state_d = ST_CLEAR;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	assign s_tready = ready;
	assign clr_addr = clr_q;

endmodule

// File: src/bpfe_datapath.sv
// Datapath: config registers, bin mapping, load memory with forwarding,
// candidate totals and the result register. Depends on bpfe_pkg.
module bpfe_datapath
	import bpfe_pkg::*;
#(
	parameter int MAX_ITEMS = 256,
	parameter int SIZE_BITS = 16,
	parameter int BIN_W     = $clog2(MAX_ITEMS)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CAP_W-1:0]      cfg_data,
	input  logic [SIZE_W-1:0]     item_size,
	input  logic [KEY_W-1:0]      item_key,
	input  bpfe_cmd_t             cmd,
	input  logic [BIN_W-1:0]      clr_addr,
	output bpfe_stat_t            stat,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [CNT_W-1:0]      used_bins,
	output logic                  infeasible
);

	localparam int ENTRY_W = EPOCH_W + CAP_W;
	localparam logic [SIZE_W-1:0] SIZE_MASK = SIZE_W'((33'd1 << SIZE_BITS) - 33'd1);

	logic [CNT_W-1:0]   item_count_q;
	logic [CAP_W-1:0]   bin_capacity_q;
	logic [CNT_W-1:0]   n_eff;
	logic [KEY_W-1:0]   key_sat;
	logic [CNT_W+KEY_W:0] prod;
	logic [BIN_W-1:0]   bin_d;

	logic               v_s1, v_s2;
	logic               last_s1, last_s2;
	logic [BIN_W-1:0]   bin_s1, bin_s2;
	logic [SIZE_W-1:0]  size_s1, size_s2;

	logic [ENTRY_W-1:0] mem [MAX_ITEMS];
	logic [ENTRY_W-1:0] rd_q;
	logic               mem_we;
	logic [BIN_W-1:0]   mem_wa;
	logic [ENTRY_W-1:0] mem_wd;

	logic               wr_valid_q;
	logic [BIN_W-1:0]   wr_bin_q;
	logic [EPOCH_W-1:0] wr_tag_q;
	logic [CAP_W-1:0]   wr_load_q;

	logic [EPOCH_W-1:0] epoch_q;
	logic [CNT_W-1:0]   used_q;
	logic               over_q;
	logic               out_valid_q;
	logic [CNT_W-1:0]   used_bins_q;
	logic               infeasible_q;

	logic               fwd;
	logic               hit;
	logic [CAP_W-1:0]   old_load;
	logic [CAP_W:0]     sum;
	logic [CAP_W-1:0]   load_new;
	logic               over_new;
	logic [CNT_W-1:0]   used_new;

	always_comb begin
		n_eff = (item_count_q == '0) ? CNT_W'(1) : item_count_q;
		if (CNT_EXT_W'(n_eff) > CNT_EXT_W'(MAX_ITEMS)) begin
			n_eff = CNT_W'(MAX_ITEMS);
		end
	end

	assign key_sat = (item_key > KEY_ONE) ? KEY_ONE : item_key;
	assign prod    = (CNT_W+KEY_W+1)'(n_eff - CNT_W'(1)) * (CNT_W+KEY_W+1)'(key_sat)
		+ (CNT_W+KEY_W+1)'(KEY_HALF);
	assign bin_d   = BIN_W'(prod[CNT_W+15:16]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_count_q   <= CNT_W'(1);
			bin_capacity_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ITEM_COUNT:   item_count_q   <= cfg_data[CNT_W-1:0];
				REG_BIN_CAPACITY: bin_capacity_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		bin_s1  <= bin_d;
		size_s1 <= item_size & SIZE_MASK;
		last_s1 <= cmd.last;
		bin_s2  <= bin_s1;
		size_s2 <= size_s1;
		last_s2 <= last_s1;
	end

	assign fwd      = wr_valid_q && (wr_bin_q == bin_s2);
	assign hit      = fwd ? (wr_tag_q == epoch_q) : (rd_q[ENTRY_W-1:CAP_W] == epoch_q);
	assign old_load = fwd ? wr_load_q : rd_q[CAP_W-1:0];
	assign sum      = (CAP_W+1)'(size_s2) + (hit ? {1'b0, old_load} : '0);
	assign load_new = sum[CAP_W] ? LOAD_MAX : sum[CAP_W-1:0];
	assign over_new = over_q || (sum > {1'b0, bin_capacity_q});
	assign used_new = used_q + (hit ? CNT_W'(0) : CNT_W'(1));

	always_comb begin
		mem_we = 1'b0;
		mem_wa = bin_s2;
		mem_wd = {epoch_q, load_new};
		if (cmd.clr_wr) begin
			mem_we = 1'b1;
			mem_wa = clr_addr;
			mem_wd = {EPOCH_CLEAR, LOAD_MAX};
		end else if (v_s2) begin
			mem_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rd_q <= mem[bin_s1];
	end

	always_ff @(posedge clk) begin
		wr_bin_q  <= bin_s2;
		wr_tag_q  <= epoch_q;
		wr_load_q <= load_new;
		if (v_s2 && last_s2) begin
			used_bins_q  <= over_new ? '0 : used_new;
			infeasible_q <= over_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			wr_valid_q  <= 1'b0;
			epoch_q     <= EPOCH_FIRST;
			used_q      <= '0;
			over_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			v_s1       <= cmd.accept;
			v_s2       <= v_s1;
			wr_valid_q <= v_s2;
			if (cmd.epoch_reset) begin
				epoch_q <= EPOCH_FIRST;
			end else if (v_s2 && last_s2) begin
				epoch_q <= epoch_q + EPOCH_W'(1);
			end
			if (v_s2) begin
				used_q <= last_s2 ? '0 : used_new;
				over_q <= last_s2 ? 1'b0 : over_new;
			end
			if (v_s2 && last_s2) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign stat.n_eff       = n_eff;
	assign stat.s1_valid    = v_s1;
	assign stat.s1_last     = last_s1;
	assign stat.s2_valid    = v_s2;
	assign stat.s2_last     = last_s2;
	assign stat.out_valid   = out_valid_q;
	assign stat.epoch_final = (epoch_q == EPOCH_LAST);

	assign m_tvalid   = out_valid_q;
	assign used_bins  = used_bins_q;
	assign infeasible = infeasible_q;

endmodule

// File: src/bin_packing_fitness_eval.sv
// Bin-packing fitness evaluator for random-key candidates. One item request per
// clock is taken sustained; each item maps its key to bin round((n-1)*key), adds
// its size to that bin's load in an on-chip load memory (one read and one write
// per cycle, with forwarding of the previous write) and the result of a
// candidate is registered once its last item has passed stages s1 and s2. The
// last item of a candidate is held off while a previous result is in flight or
// still waiting to be taken. Every load entry carries an 8-bit candidate tag,
// so no per-bin clearing is needed; after reset, and again after every 255
// candidates, the block clears all MAX_ITEMS entries, accepting no item meanwhile.
// Depends on bpfe_pkg, bpfe_ctrl and bpfe_datapath.
module bin_packing_fitness_eval
	import bpfe_pkg::*;
#(
	parameter int MAX_ITEMS = 256,
	parameter int SIZE_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CAP_W-1:0]      cfg_data,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // item_size[15:0], item_key[32:16], zero pad
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata    // used_bins[8:0], infeasible[9], zero pad
);

	localparam int BIN_W = $clog2(MAX_ITEMS);

	bpfe_cmd_t        cmd;
	bpfe_stat_t       stat;
	logic [BIN_W-1:0] clr_addr;
	logic [CNT_W-1:0] used_bins;
	logic             infeasible;

	bpfe_ctrl #(
		.MAX_ITEMS (MAX_ITEMS),
		.BIN_W     (BIN_W)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd),
		.clr_addr (clr_addr)
	);

	bpfe_datapath #(
		.MAX_ITEMS (MAX_ITEMS),
		.SIZE_BITS (SIZE_BITS),
		.BIN_W     (BIN_W)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.item_size  (s_tdata[SIZE_W-1:0]),
		.item_key   (s_tdata[SIZE_W+KEY_W-1:SIZE_W]),
		.cmd        (cmd),
		.clr_addr   (clr_addr),
		.stat       (stat),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.used_bins  (used_bins),
		.infeasible (infeasible)
	);

	assign m_tdata = {(OUT_DATA_W-CNT_W-1)'(0), infeasible, used_bins};

endmodule

// File: src/bpfe_checker.sv
// Port-level checks for bin_packing_fitness_eval, attached by bind.
// Depends on bpfe_pkg and the top level's ports.
module bpfe_checker
	import bpfe_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result request dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("result payload changed while stalled");

	a_infeasible_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[CNT_W] |-> m_tdata[CNT_W-1:0] == '0)
		else $error("infeasible result with nonzero bin count");

	a_feasible_used: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[CNT_W] |-> m_tdata[CNT_W-1:0] != '0)
		else $error("feasible result with no used bin");

endmodule

bind bin_packing_fitness_eval bpfe_checker u_bpfe_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// File: dv/tb_bin_packing_fitness_eval.sv
`timescale 1ns / 100ps
// Self-checking bench for bin_packing_fitness_eval: streams random-key candidates
// and checks each bin count / infeasible flag against a bin-load predictor.
// Depends on bpfe_pkg and the RTL top only.
module tb_bin_packing_fitness_eval;
	import bpfe_pkg::*;

	localparam int MAX_ITEMS    = 256;
	localparam int CLK_PERIOD   = 10;
	localparam int SETTLE       = 12;
	localparam int CYCLE_LIMIT  = 600000;
	localparam int RANDOM_ITEMS = 600;

	typedef struct packed {
		logic [KEY_W-1:0]  key;
		logic [SIZE_W-1:0] size;
	} item_t;

	typedef struct {
		logic [CNT_W-1:0] used_bins;
		logic             infeasible;
	} fitness_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CAP_W-1:0]      cfg_data = '0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;    // item_size[15:0], item_key[32:16], zero pad
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;         // used_bins[8:0], infeasible[9], zero pad

	// predictor state
	logic [CAP_W-1:0] est_load [MAX_ITEMS];
	logic             est_used [MAX_ITEMS];
	logic [CNT_W-1:0] est_used_cnt;
	logic [CNT_W-1:0] est_seen;
	logic             est_over;
	logic [CNT_W-1:0] cfg_count_q = 9'd1;
	logic [CAP_W-1:0] cfg_cap_q   = '0;

	item_t    item_q[$];
	fitness_t fitness_q[$];

	int unsigned items_queued = 0;
	int unsigned items_taken  = 0;
	int unsigned results_seen = 0;
	int unsigned infeasible_seen = 0;
	int unsigned err_cnt      = 0;
	int unsigned cycle_cnt    = 0;
	int unsigned settings_cnt = 0;
	int unsigned src_idle_pct = 0;
	int unsigned snk_stall_pct = 0;

	bin_packing_fitness_eval #(
		.MAX_ITEMS(MAX_ITEMS),
		.SIZE_BITS(SIZE_W)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	task automatic clear_bins();
		for (int i = 0; i < MAX_ITEMS; i++) begin
			est_load[i] = '0;
			est_used[i] = 1'b0;
		end
		est_used_cnt = '0;
		est_seen     = '0;
		est_over     = 1'b0;
	endtask

	initial clear_bins();

	// one accepted item through the bin-load predictor
	task automatic score_item(input item_t it);
		int unsigned      n;
		int unsigned      b;
		logic [KEY_W-1:0] k;
		logic [63:0]      sum;
		fitness_t         r;
		n = (cfg_count_q == 0) ? 1 : ((cfg_count_q > MAX_ITEMS) ? MAX_ITEMS : cfg_count_q);
		k = (it.key > KEY_ONE) ? KEY_ONE : it.key;
		b = ((n - 1) * k + KEY_HALF) >> 16;
		if (b >= n)
			b = n - 1;
		sum = 64'(it.size) + (est_used[b] ? 64'(est_load[b]) : 64'd0);
		if (sum > 64'(cfg_cap_q))
			est_over = 1'b1;
		est_load[b] = (sum > 64'(LOAD_MAX)) ? LOAD_MAX : sum[CAP_W-1:0];
		if (!est_used[b]) begin
			est_used[b]  = 1'b1;
			est_used_cnt = est_used_cnt + 1'b1;
		end
		est_seen = est_seen + 1'b1;
		if (est_seen >= n) begin
			r.infeasible = est_over;
			r.used_bins  = est_over ? '0 : est_used_cnt;
			fitness_q.push_back(r);
			clear_bins();
		end
	endtask

	task automatic report_mismatch(input string what);
		err_cnt++;
		if (err_cnt <= 10)
			$display("[%0t] %s", $realtime, what);
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
		end else if (!s_tvalid || s_tready) begin
			if (item_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
				s_tdata  <= {{(IN_DATA_W - KEY_W - SIZE_W){1'b0}}, item_q.pop_front()};
				s_tvalid <= 1'b1;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tready <= 1'b0;
		else
			m_tready <= ($urandom_range(99) >= snk_stall_pct);
	end

	// monitor: results checked before the new request is scored
	always @(posedge clk) begin
		fitness_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (m_tdata[CNT_W])
					infeasible_seen++;
				if (fitness_q.size() == 0) begin
					report_mismatch($sformatf("unexpected result used_bins=%0d infeasible=%0b",
						m_tdata[CNT_W-1:0], m_tdata[CNT_W]));
				end else begin
					want = fitness_q.pop_front();
					if (m_tdata[CNT_W-1:0] !== want.used_bins || m_tdata[CNT_W] !== want.infeasible)
						report_mismatch($sformatf(
							"result %0d: exp used_bins=%0d infeasible=%0b, got used_bins=%0d infeasible=%0b",
							results_seen, want.used_bins, want.infeasible,
							m_tdata[CNT_W-1:0], m_tdata[CNT_W]));
				end
			end
			if (s_tvalid && s_tready) begin
				items_taken++;
				score_item(item_t'(s_tdata[KEY_W+SIZE_W-1:0]));
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
				fitness_q.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic queue_item(input logic [SIZE_W-1:0] size, input logic [KEY_W-1:0] key);
		item_t it;
		it.size = size;
		it.key  = key;
		item_q.push_back(it);
		items_queued++;
	endtask

	// all requests taken, all results back, then let the pipeline drain
	task automatic wait_idle();
		while (items_taken != items_queued || fitness_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CAP_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we    <= 1'b0;
		case (idx)
			REG_ITEM_COUNT:   cfg_count_q = val[CNT_W-1:0];
			REG_BIN_CAPACITY: cfg_cap_q   = val;
			default: ;
		endcase
		settings_cnt++;
	endtask

	task automatic queue_random_items(input int unsigned total, input int unsigned n);
		int unsigned      sel;
		int unsigned      b;
		logic [SIZE_W-1:0] size;
		logic [KEY_W-1:0]  key;
		for (int i = 0; i < total; i++) begin
			sel = $urandom_range(99);
			if (sel < 50)      size = SIZE_W'($urandom_range(16'hFFFF));
			else if (sel < 80) size = SIZE_W'($urandom_range(1023));
			else if (sel < 90) size = '0;
			else               size = 16'hFFFF;
			sel = $urandom_range(99);
			if (sel < 70) begin
				key = KEY_W'($urandom_range(KEY_ONE));
			end else if (sel < 85) begin
				key = KEY_W'($urandom_range(17'h1FFFF, KEY_ONE + 1));
			end else if (sel < 95 || n < 2) begin
				key = $urandom_range(1) ? KEY_ONE : '0;
			end else begin
				// either side of a rounding boundary between two bins
				b   = $urandom_range(n - 2);
				key = KEY_W'(((2 * b + 1) * KEY_HALF) / (n - 1) + $urandom_range(1));
			end
			queue_item(size, key);
		end
	endtask

	int unsigned src_pct_tab [5] = '{0, 79, 0, 15, 0};
	int unsigned snk_pct_tab [5] = '{0, 0, 79, 15, 0};

	initial begin
		int unsigned phase;
		int unsigned sel;
		int unsigned count;
		int unsigned n_eff;
		int unsigned total;
		int unsigned rand_base;
		int unsigned max_n;
		logic [CAP_W-1:0] cap;
		phase = 0;
		max_n = 1;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: one item per candidate, capacity zero
		queue_item('0, '0);
		queue_item(16'd1, KEY_ONE);
		wait_idle();

		// half rounds up; exact fill then one over
		write_reg(REG_ITEM_COUNT, 24'd2);
		write_reg(REG_BIN_CAPACITY, 24'd65535);
		queue_item(16'hFFFF, KEY_HALF);
		queue_item('0, KEY_HALF - 17'd1);
		queue_item(16'hFFFF, '0);
		queue_item(16'd1, '0);
		wait_idle();

		// key above one saturates onto the last bin
		write_reg(REG_ITEM_COUNT, 24'd3);
		write_reg(REG_BIN_CAPACITY, LOAD_MAX);
		queue_item(16'h5555, 17'd16384);
		queue_item(16'hAAAA, 17'h1FFFF);
		queue_item(16'hFFFF, KEY_ONE);
		wait_idle();

		// count of zero acts as one
		write_reg(REG_ITEM_COUNT, 24'd0);
		queue_item(16'h1234, 17'h0AAAA);
		wait_idle();

		// count lowered mid-candidate: next item closes it
		write_reg(REG_ITEM_COUNT, 24'd4);
		queue_item(16'h00FF, 17'h15555);
		queue_item(16'hFF00, 17'h0C000);
		wait_idle();
		write_reg(REG_ITEM_COUNT, 24'd2);
		queue_item(16'h8001, 17'h10000);
		wait_idle();

		rand_base = items_queued;
		while (items_queued < rand_base + RANDOM_ITEMS) begin
			src_idle_pct  = src_pct_tab[phase % 5];
			snk_stall_pct = snk_pct_tab[phase % 5];
			sel = $urandom_range(99);
			if (sel < 80)      count = $urandom_range(8, 1);
			else if (sel < 93) count = $urandom_range(64, 9);
			else if (sel < 96) count = $urandom_range(256, 255);
			else               count = $urandom_range(511, 257);
			n_eff = (count > MAX_ITEMS) ? MAX_ITEMS : count;
			if (n_eff > max_n)
				max_n = n_eff;
			sel = $urandom_range(99);
			if (sel < 25)      cap = '0;
			else if (sel < 45) cap = LOAD_MAX;
			else if (sel < 80) cap = CAP_W'($urandom_range(131071));
			else               cap = CAP_W'($urandom_range(LOAD_MAX));
			write_reg(REG_ITEM_COUNT, {15'($urandom), 9'(count)});
			write_reg(REG_BIN_CAPACITY, cap);
			total = (n_eff > 64) ? n_eff : n_eff * $urandom_range(4, 1);
			if (n_eff > 1 && $urandom_range(3) == 0)
				total += $urandom_range(n_eff - 1, 1);
			queue_random_items(total, n_eff);
			wait_idle();
			phase++;
		end

		$display("%0d requests over %0d register writes; %0d candidates scored, %0d infeasible",
			items_taken, settings_cnt, results_seen, infeasible_seen);
		$display("largest effective item count %0d, %0d mismatches", max_n, err_cnt);
		if (err_cnt == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
